>>> rtl/core/ntc_beta_temperature_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the NTC beta temperature block.
// Both macros expect signals named clk and rst where they are used.
// ----------------------------------------------------------------------------
`ifndef NTC_BETA_TEMPERATURE_TOP_ASSERT_SVH
`define NTC_BETA_TEMPERATURE_TOP_ASSERT_SVH

// Same-cycle implication.
`define NTC_BT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define NTC_BT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/ntc_bt_pkg.sv
// ----------------------------------------------------------------------------
// ntc_bt_pkg
// Widths, constants and shared types of the NTC beta temperature block.
// ----------------------------------------------------------------------------
package ntc_bt_pkg;

  localparam int MV_W       = 12;
  localparam int OHM_W      = 20;
  localparam int BETA_W     = 14;
  localparam int T0_W       = 16;
  localparam int TEMP_W     = 18;
  localparam int NTC_W      = 26;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam int LOG_IN_W      = 32;
  localparam int LOG_INT_W     = 5;
  localparam int LOG_FRAC_BITS = 44;
  localparam int LOG_W         = LOG_INT_W + LOG_FRAC_BITS;

  localparam logic [63:0] LN2_Q64 = 64'hB17217F7D1CF79AB;

  localparam logic [NTC_W-1:0]   OHMS_MAX  = {NTC_W{1'b1}};
  localparam logic signed [21:0] TEMP_HIGH = 22'sd100000;
  localparam logic signed [21:0] TEMP_LOW  = -22'sd30000;
  localparam logic signed [21:0] ZERO_C_CK = 22'sd27315;
  localparam logic [19:0]        Q_CLAMP   = 20'd1000000;

  localparam logic [MV_W-1:0]   RST_SUPPLY  = 12'd3300;
  localparam logic [OHM_W-1:0]  RST_SERIES  = 20'd10000;
  localparam logic [OHM_W-1:0]  RST_NOMINAL = 20'd10000;
  localparam logic [BETA_W-1:0] RST_BETA    = 14'd3950;
  localparam logic [T0_W-1:0]   RST_T0      = 16'd29815;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SUPPLY  = 3'd0,
    REG_SERIES  = 3'd1,
    REG_NOMINAL = 3'd2,
    REG_BETA    = 3'd3,
    REG_T0      = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic        keep;
    logic [31:0] n;
    logic [31:0] d;
  } div_side_t;

  typedef struct packed {
    logic             keep;
    logic             dpos;
    logic             dzero;
    logic [NTC_W-1:0] ohms;
  } tdiv_side_t;

endpackage

>>> rtl/core/ntc_bt_udiv.sv
// ----------------------------------------------------------------------------
// ntc_bt_udiv
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// ----------------------------------------------------------------------------
module ntc_bt_udiv #(
  parameter int NW = 34,
  parameter int DW = 13,
  parameter int QW = 26,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [QW-1:0] quo,
  output logic          sat,
  output logic [SW-1:0] out_side
);

  localparam int CW = (NW > DW + QW) ? NW : DW + QW;

  logic [CW-1:0] rem_e  [0:QW];
  logic [DW-1:0] den_e  [0:QW];
  logic [QW-1:0] q_e    [0:QW];
  logic          sat_e  [0:QW];
  logic [SW-1:0] side_e [0:QW];
  logic          vld_e  [0:QW];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_e[0] <= 1'b0;
    end else if (en) begin
      vld_e[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_e[0]  <= CW'(num);
      den_e[0]  <= den;
      q_e[0]    <= '0;
      sat_e[0]  <= CW'(num) >= (CW'(den) << QW);
      side_e[0] <= in_side;
    end
  end

  for (genvar st = 0; st < QW; st++) begin : g_stage
    localparam int B = QW - 1 - st;
    logic [CW-1:0] trial;
    logic          ge;

    assign trial = CW'(den_e[st]) << B;
    assign ge    = rem_e[st] >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_e[st+1] <= 1'b0;
      end else if (en) begin
        vld_e[st+1] <= vld_e[st];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_e[st+1]  <= ge ? rem_e[st] - trial : rem_e[st];
        den_e[st+1]  <= den_e[st];
        q_e[st+1]    <= {q_e[st][QW-2:0], ge};
        sat_e[st+1]  <= sat_e[st];
        side_e[st+1] <= side_e[st];
      end
    end
  end

  assign out_valid = vld_e[QW];
  assign quo       = q_e[QW];
  assign sat       = sat_e[QW];
  assign out_side  = side_e[QW];

endmodule

>>> rtl/core/ntc_bt_log2.sv
// ----------------------------------------------------------------------------
// ntc_bt_log2
// Pipelined binary logarithm in Q44 by repeated squaring of the mantissa.
// ----------------------------------------------------------------------------
module ntc_bt_log2 import ntc_bt_pkg::*; #(
  parameter int SW = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [LOG_IN_W-1:0] x,
  input  logic [SW-1:0]       in_side,
  output logic                out_valid,
  output logic [LOG_W-1:0]    log2_q,
  output logic [SW-1:0]       out_side
);

  localparam int ITER = LOG_FRAC_BITS;
  localparam int MW   = 63;

  logic [LOG_INT_W-1:0] k_comb;
  logic [LOG_IN_W-1:0]  x_n;
  logic [LOG_INT_W-1:0] k_n;
  logic [SW-1:0]        side_n;
  logic                 vld_n;
  logic [5:0]           sh;

  logic [MW-1:0]            m_e   [0:ITER];
  logic [ITER-1:0]          fr_e  [0:ITER];
  logic [LOG_INT_W-1:0]     k_e   [0:ITER];
  logic [SW-1:0]            sd_e  [0:ITER];
  logic                     vl_e  [0:ITER];

  logic [61:0]              ph_a  [0:ITER-1];
  logic [62:0]              pm_a  [0:ITER-1];
  logic [63:0]              pl_a  [0:ITER-1];
  logic [ITER-1:0]          fr_a  [0:ITER-1];
  logic [LOG_INT_W-1:0]     kk_a  [0:ITER-1];
  logic [SW-1:0]            sd_a  [0:ITER-1];
  logic                     vl_a  [0:ITER-1];

  always_comb begin
    k_comb = '0;
    for (int i = 0; i < LOG_IN_W; i++) begin
      if (x[i]) begin
        k_comb = LOG_INT_W'(i);
      end
    end
  end

  assign sh = 6'd62 - {1'b0, k_n};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_n    <= 1'b0;
      vl_e[0]  <= 1'b0;
    end else if (en) begin
      vld_n    <= in_valid;
      vl_e[0]  <= vld_n;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_n     <= x;
      k_n     <= k_comb;
      side_n  <= in_side;
      m_e[0]  <= {31'd0, x_n} << sh;
      fr_e[0] <= '0;
      k_e[0]  <= k_n;
      sd_e[0] <= side_n;
    end
  end

  for (genvar i = 0; i < ITER; i++) begin : g_iter
    logic [125:0] sq;
    logic [63:0]  mp;

    assign sq = {ph_a[i], 64'd0} + 126'({pm_a[i], 33'd0}) + 126'(pl_a[i]);
    assign mp = sq[125:62];

    always_ff @(posedge clk) begin
      if (rst) begin
        vl_a[i]   <= 1'b0;
        vl_e[i+1] <= 1'b0;
      end else if (en) begin
        vl_a[i]   <= vl_e[i];
        vl_e[i+1] <= vl_a[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ph_a[i]   <= {31'd0, m_e[i][62:32]} * {31'd0, m_e[i][62:32]};
        pm_a[i]   <= {32'd0, m_e[i][62:32]} * {31'd0, m_e[i][31:0]};
        pl_a[i]   <= {32'd0, m_e[i][31:0]} * {32'd0, m_e[i][31:0]};
        fr_a[i]   <= fr_e[i];
        kk_a[i]   <= k_e[i];
        sd_a[i]   <= sd_e[i];
        m_e[i+1]  <= mp[63] ? mp[63:1] : mp[62:0];
        fr_e[i+1] <= {fr_a[i][ITER-2:0], mp[63]};
        k_e[i+1]  <= kk_a[i];
        sd_e[i+1] <= sd_a[i];
      end
    end
  end

  assign out_valid = vl_e[ITER];
  assign log2_q    = {k_e[ITER], fr_e[ITER]};
  assign out_side  = sd_e[ITER];

endmodule

>>> rtl/core/ntc_beta_temperature_top.sv
// ----------------------------------------------------------------------------
// ntc_beta_temperature_top
// Throughput: one word per cycle while the skid word is empty; the
// resistance divider, two log units and the temperature divider are fully
// pipelined, with one quotient bit or one log fraction bit per iteration.
// Reset clears all valid bits and loads the default configuration registers.
// ----------------------------------------------------------------------------
module ntc_beta_temperature_top import ntc_bt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [15:0]           s_tdata,   // [11:0] voltage_mv
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [47:0]           m_tdata,   // [17:0] temp_centi_celsius, [43:18] ntc_ohms
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [MV_W-1:0]   supply;
  logic [OHM_W-1:0]  series;
  logic [OHM_W-1:0]  nominal;
  logic [BETA_W-1:0] beta;
  logic [T0_W-1:0]   t0;
  logic [OHM_W-1:0]  nom_eff;
  logic [BETA_W-1:0] beta_eff;
  logic [20:0]       b100;
  logic [36:0]       cval;

  logic en;
  logic skid_valid;
  logic [47:0] skid_data;
  logic push;
  logic [47:0] fin_word;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      supply  <= RST_SUPPLY;
      series  <= RST_SERIES;
      nominal <= RST_NOMINAL;
      beta    <= RST_BETA;
      t0      <= RST_T0;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_SUPPLY:  supply  <= cfg_data[MV_W-1:0];
        REG_SERIES:  series  <= cfg_data[OHM_W-1:0];
        REG_NOMINAL: nominal <= cfg_data[OHM_W-1:0];
        REG_BETA:    beta    <= cfg_data[BETA_W-1:0];
        REG_T0:      t0      <= cfg_data[T0_W-1:0];
        default: ;
      endcase
    end
  end

  assign nom_eff  = (nominal == '0) ? OHM_W'(1) : nominal;
  assign beta_eff = (beta == '0) ? BETA_W'(1) : beta;

  always_ff @(posedge clk) begin
    b100 <= {7'd0, beta_eff} * 21'd100;
    cval <= {16'd0, b100} * {21'd0, t0};
  end

  assign en       = !skid_valid;
  assign s_tready = en;

  // Input register and products.
  logic            vld1, vld2, keep2;
  logic [MV_W-1:0] v1, dv2;
  logic [31:0]     n2, d2;
  logic [MV_W-1:0] dv1;

  assign dv1 = supply - v1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
    end else if (en) begin
      vld1 <= s_tvalid;
      vld2 <= vld1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v1    <= s_tdata[MV_W-1:0];
      dv2   <= dv1;
      n2    <= {12'd0, series} * {20'd0, v1};
      d2    <= {12'd0, nom_eff} * {20'd0, dv1};
      keep2 <= (v1 != '0) && (v1 < supply);
    end
  end

  // Thermistor resistance.
  div_side_t        od_in, od_s;
  logic [$bits(div_side_t)-1:0] od_vec;
  logic             od_valid, od_sat;
  logic [NTC_W-1:0] od_q, ohms_d;

  assign od_in.keep = keep2 && (n2 != '0);
  assign od_in.n    = n2;
  assign od_in.d    = d2;

  ntc_bt_udiv #(
    .NW(34), .DW(13), .QW(NTC_W), .SW($bits(div_side_t))
  ) u_ohms_div (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(vld2),
    .num({1'b0, n2, 1'b0} + 34'(dv2)),
    .den({dv2, 1'b0}),
    .in_side(od_in),
    .out_valid(od_valid), .quo(od_q), .sat(od_sat), .out_side(od_vec)
  );

  assign od_s   = od_vec;
  assign ohms_d = od_sat ? OHMS_MAX : od_q;

  // Logarithms of numerator and denominator.
  logic             la_valid, lb_valid;
  logic [LOG_W-1:0] la, lb;
  logic [NTC_W-1:0] la_ohms;
  logic             lb_keep;

  ntc_bt_log2 #(.SW(NTC_W)) u_log_n (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(od_valid), .x(od_s.n), .in_side(ohms_d),
    .out_valid(la_valid), .log2_q(la), .out_side(la_ohms)
  );

  ntc_bt_log2 #(.SW(1)) u_log_d (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(od_valid), .x(od_s.d), .in_side(od_s.keep),
    .out_valid(lb_valid), .log2_q(lb), .out_side(lb_keep)
  );

  // Difference, then ln(R/R0) in Q40, then the denominator.
  logic [LOG_W:0]   diff, ndiff;
  logic             vldL, negL, keepL;
  logic [48:0]      magL;
  logic [NTC_W-1:0] ohmsL;

  assign diff  = {1'b0, la} - {1'b0, lb};
  assign ndiff = -diff;

  logic             vldM1, vldM2, vldM3, negM1, negM2, negM3, keepM1, keepM2, keepM3;
  logic [NTC_W-1:0] ohmsM1, ohmsM2, ohmsM3;
  logic [56:0]      m00, m01;
  logic [55:0]      m10, m11;
  logic [112:0]     full;
  logic [48:0]      hiM;
  logic [45:0]      lqM;

  assign full = 113'(m00) + (113'(m01) << 32) + (113'(m10) << 25) + (113'(m11) << 57);

  logic             vldP1, vldP2, negP1, negP2, keepP1, keepP2;
  logic [NTC_W-1:0] ohmsP1, ohmsP2;
  logic [38:0]      pa0, pa1;
  logic [61:0]      pP;

  logic             vldD, keepD, dposD;
  logic [NTC_W-1:0] ohmsD;
  logic [62:0]      dmD, a63, p63, dm_c;
  logic             dpos_c;

  assign a63 = {2'd0, b100, 40'd0};
  assign p63 = {1'b0, pP};

  always_comb begin
    dpos_c = 1'b1;
    if (!negP2) begin
      dm_c = a63 + p63;
    end else if (a63 >= p63) begin
      dm_c = a63 - p63;
    end else begin
      dm_c   = p63 - a63;
      dpos_c = 1'b0;
    end
  end

  logic             vldN;
  tdiv_side_t       tsN;
  logic [78:0]      numN;
  logic [63:0]      denN;

  always_ff @(posedge clk) begin
    if (rst) begin
      vldL  <= 1'b0;
      vldM1 <= 1'b0;
      vldM2 <= 1'b0;
      vldM3 <= 1'b0;
      vldP1 <= 1'b0;
      vldP2 <= 1'b0;
      vldD  <= 1'b0;
      vldN  <= 1'b0;
    end else if (en) begin
      vldL  <= la_valid & lb_valid;
      vldM1 <= vldL;
      vldM2 <= vldM1;
      vldM3 <= vldM2;
      vldP1 <= vldM3;
      vldP2 <= vldP1;
      vldD  <= vldP2;
      vldN  <= vldD;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      negL   <= diff[LOG_W];
      magL   <= diff[LOG_W] ? ndiff[48:0] : diff[48:0];
      ohmsL  <= la_ohms;
      keepL  <= lb_keep;

      m00    <= {32'd0, magL[24:0]}  * {25'd0, LN2_Q64[31:0]};
      m01    <= {32'd0, magL[24:0]}  * {25'd0, LN2_Q64[63:32]};
      m10    <= {32'd0, magL[48:25]} * {24'd0, LN2_Q64[31:0]};
      m11    <= {32'd0, magL[48:25]} * {24'd0, LN2_Q64[63:32]};
      negM1  <= negL;
      ohmsM1 <= ohmsL;
      keepM1 <= keepL;

      hiM    <= full[112:64];
      negM2  <= negM1;
      ohmsM2 <= ohmsM1;
      keepM2 <= keepM1;

      lqM    <= 46'(hiM[48:4]) + 46'(hiM[3]);
      negM3  <= negM2;
      ohmsM3 <= ohmsM2;
      keepM3 <= keepM2;

      pa0    <= {23'd0, t0} * {16'd0, lqM[22:0]};
      pa1    <= {23'd0, t0} * {16'd0, lqM[45:23]};
      negP1  <= negM3;
      ohmsP1 <= ohmsM3;
      keepP1 <= keepM3;

      pP     <= (62'(pa1) << 23) + 62'(pa0);
      negP2  <= negP1;
      ohmsP2 <= ohmsP1;
      keepP2 <= keepP1;

      dmD    <= dm_c;
      dposD  <= dpos_c;
      ohmsD  <= ohmsP2;
      keepD  <= keepP2;

      numN      <= (79'(cval) << 41) + 79'(dmD);
      denN      <= {dmD, 1'b0};
      tsN.keep  <= keepD;
      tsN.dpos  <= dposD;
      tsN.dzero <= (dmD == '0);
      tsN.ohms  <= ohmsD;
    end
  end

  // Kelvin in hundredths.
  logic        tv_valid, t_sat;
  logic [19:0] t_q, qc;
  logic [$bits(tdiv_side_t)-1:0] ts_vec;
  tdiv_side_t  ts;

  ntc_bt_udiv #(
    .NW(79), .DW(64), .QW(20), .SW($bits(tdiv_side_t))
  ) u_temp_div (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(vldN), .num(numN), .den(denN), .in_side(tsN),
    .out_valid(tv_valid), .quo(t_q), .sat(t_sat), .out_side(ts_vec)
  );

  assign ts = ts_vec;

  logic signed [21:0] tq, tc;

  always_comb begin
    qc = (t_sat || (t_q > Q_CLAMP)) ? Q_CLAMP : t_q;
    if (ts.dpos) begin
      tq = $signed({2'b00, qc}) - ZERO_C_CK;
    end else begin
      tq = -$signed({2'b00, qc}) - ZERO_C_CK;
    end
    if (ts.dzero) begin
      tc = TEMP_HIGH;
    end else if (tq > TEMP_HIGH) begin
      tc = TEMP_HIGH;
    end else if (tq < TEMP_LOW) begin
      tc = TEMP_LOW;
    end else begin
      tc = tq;
    end
  end

  logic              vldF;
  logic [TEMP_W-1:0] tempF;
  logic [NTC_W-1:0]  ohmsF;

  always_ff @(posedge clk) begin
    if (rst) begin
      vldF <= 1'b0;
    end else if (en) begin
      vldF <= tv_valid & ts.keep;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tempF <= tc[TEMP_W-1:0];
      ohmsF <= ts.ohms;
    end
  end

  // Output register with skid word.
  assign fin_word = {4'd0, ohmsF, tempF};
  assign push     = vldF & en;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_tready || !m_tvalid) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_tready || !m_tvalid) begin
      m_tdata <= skid_valid ? skid_data : fin_word;
    end else if (push) begin
      skid_data <= fin_word;
    end
  end

endmodule

>>> rtl/core/ntc_bt_checker.sv
// ----------------------------------------------------------------------------
// ntc_bt_checker
// Port-level checks of the NTC beta temperature block, bound to the top level.
// ----------------------------------------------------------------------------
`include "ntc_beta_temperature_top_assert.svh"

module ntc_bt_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata
);

  `NTC_BT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output word changed while stalled")
  `NTC_BT_ASSERT_SAME(a_temp_range, m_tvalid, ($signed(m_tdata[17:0]) >= -30000) && ($signed(m_tdata[17:0]) <= 100000), "temperature outside saturation range")
  `NTC_BT_ASSERT_SAME(a_reset_empty, $past(rst), !m_tvalid, "output word present right after reset")
  `NTC_BT_ASSERT_SAME(a_stall_cause, !s_tready, m_tvalid, "input stalled with no output word waiting")

endmodule

bind ntc_beta_temperature_top ntc_bt_checker u_ntc_bt_checker (.*);
